// ----- sv/simon128_256_ctr_keystream_core_defines.svh -----
// Assertion macros for the Simon 128/256 counter-mode keystream core.
`ifndef SIMON128_256_CTR_KEYSTREAM_CORE_DEFINES_SVH
`define SIMON128_256_CTR_KEYSTREAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, checked at every rising clock edge outside reset
`define SIMCTR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define SIMCTR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle
`define SIMCTR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SIMCTR_ASSERT(lbl, clk, rst, prop, msg)
`define SIMCTR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SIMCTR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- sv/simctr_pkg.sv -----
// Types, constants and helper functions shared by the Simon counter-mode core.
package simctr_pkg;

  localparam int WORD_W     = 64;
  localparam int BYTES_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int ROUNDS_DEF = 72;

  localparam logic [WORD_W-1:0]  KS_CONST   = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam logic [WORD_W-1:0]  SEQ_CONST  = 64'hFDC9_4C3A_046D_678B;
  localparam logic [BYTES_W-1:0] FULL_BYTES = 5'd16;
  localparam logic [BYTES_W-1:0] HALF_BYTES = 5'd8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD0  = 3'd0,
    CFG_KEY_WORD1  = 3'd1,
    CFG_KEY_WORD2  = 3'd2,
    CFG_KEY_WORD3  = 3'd3,
    CFG_NONCE_LOW  = 3'd4,
    CFG_NONCE_HIGH = 3'd5
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_KEXP,
    S_PREF,
    S_ROUND,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               restart;
    logic [WORD_W-1:0]  data_low;
    logic [WORD_W-1:0]  data_high;
    logic [BYTES_W-1:0] valid_bytes;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0]  out_low;
    logic [WORD_W-1:0]  out_high;
    logic [BYTES_W-1:0] out_bytes;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // take the input word
    logic load_ctr;  // counter from nonce registers
    logic load_xy;   // cipher state from counter
    logic kexp;      // one key schedule step
    logic round;     // one cipher round
    logic finish;    // write result, step counter on a full block
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic restart;
    logic out_free;
  } status_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                             input int unsigned r);
    return (v >> r) | (v << (WORD_W - r));
  endfunction

  // Simon round function
  function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] v);
    return (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
  endfunction

  // Mask keeping the lowest n bytes of a word (n of 8 or more keeps all)
  function automatic logic [WORD_W-1:0] byte_mask(input logic [BYTES_W-1:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W / 8; b++) begin
      m[8*b +: 8] = (n > BYTES_W'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- sv/simon128_256_ctr_keystream_core.sv -----
// Simon 128/256 counter-mode keystream core: one 16-byte data word in, one out.
// A new word is taken only after the last one's result is written; a restart word
// also runs the key schedule first. The rate is set by the single shared round unit
// (one round per cycle) and the one-key-per-cycle schedule.
// Reset (synchronous, rst high) clears config, counter and round-key valid bits
// at once; no clearing pass, the block is ready the cycle after reset.
module simon128_256_ctr_keystream_core
  import simctr_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word
);

  localparam int RW = $clog2(ROUNDS);

  cmd_t          cmd;
  status_t       status;
  logic [RW-1:0] idx;
  logic [RW-1:0] rd_addr;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  simctr_ctrl #(
    .ROUNDS (ROUNDS),
    .RW     (RW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .idx      (idx),
    .rd_addr  (rd_addr)
  );

  simctr_dp #(
    .ROUNDS (ROUNDS),
    .RW     (RW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .idx       (idx),
    .rd_addr   (rd_addr),
    .status    (status)
  );

endmodule

// ----- sv/simctr_ctrl.sv -----
// Sequencer for key expansion, cipher rounds and result hand-off.
`include "simon128_256_ctr_keystream_core_defines.svh"

module simctr_ctrl
  import simctr_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF,
  parameter int RW     = $clog2(ROUNDS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  status_t       status,
  output cmd_t          cmd,
  output logic [RW-1:0] idx,
  output logic [RW-1:0] rd_addr
);

  localparam logic [RW-1:0] LAST = RW'(ROUNDS - 1);

  state_e state, state_next;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == S_KEXP || state == S_ROUND) begin
        idx <= idx + RW'(1);
      end else begin
        idx <= '0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SETUP;
      S_SETUP: state_next = status.restart ? S_KEXP : S_ROUND;
      S_KEXP:  if (idx == LAST) state_next = S_PREF;
      S_PREF:  state_next = S_ROUND;
      S_ROUND: if (idx == LAST) state_next = S_DONE;
      S_DONE:  if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    rd_addr  = '0;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_SETUP: begin
        cmd.load_ctr = status.restart;
        cmd.load_xy  = !status.restart;
      end
      S_KEXP:  cmd.kexp = 1'b1;
      S_PREF:  cmd.load_xy = 1'b1;
      S_ROUND: begin
        cmd.round = 1'b1;
        rd_addr   = (idx == LAST) ? '0 : idx + RW'(1);
      end
      S_DONE:  cmd.finish = status.out_free;
      default: cmd = '0;
    endcase
  end

  `SIMCTR_ASSERT_NXT(a_kexp_end, clk, rst, state == S_KEXP && idx == LAST, state == S_PREF, "key schedule did not end after last step")
  `SIMCTR_ASSERT_NXT(a_round_end, clk, rst, state == S_ROUND && idx == LAST, state == S_DONE, "rounds did not end after last round")
  `SIMCTR_ASSERT_IMP(a_round_start, clk, rst, (state != S_ROUND) ##1 (state == S_ROUND), idx == '0, "rounds started at nonzero step")
  `SIMCTR_ASSERT_NXT(a_done_leave, clk, rst, state == S_DONE && status.out_free, state == S_IDLE && !in_stall, "result written but input still stalled")

endmodule

// ----- sv/simctr_dp.sv -----
// Datapath: config registers, round-key memory, key schedule, round unit, counter, output.
module simctr_dp
  import simctr_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF,
  parameter int RW     = $clog2(ROUNDS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  cmd_t                 cmd,
  input  logic [RW-1:0]        idx,
  input  logic [RW-1:0]        rd_addr,
  output status_t              status
);

  logic [WORD_W-1:0] key_word0, key_word1, key_word2, key_word3;
  logic [WORD_W-1:0] nonce_low, nonce_high;
  logic [WORD_W-1:0] ctr_low, ctr_high;
  logic [WORD_W-1:0] data_low, data_high;
  logic [BYTES_W-1:0] nbytes;
  logic restart;
  logic [WORD_W-1:0] x, y;
  logic [WORD_W-1:0] kw0, kw1, kw2, kw3;
  logic [WORD_W-1:0] mem [ROUNDS];
  logic [ROUNDS-1:0] kvalid;
  logic [WORD_W-1:0] rdata;
  logic rvalid;
  logic [WORD_W-1:0] rkey, new_key, seed;
  logic [RW-1:0] j;
  logic zbit;
  logic [WORD_W-1:0] mask_low, mask_high;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0  <= '0;
      key_word1  <= '0;
      key_word2  <= '0;
      key_word3  <= '0;
      nonce_low  <= '0;
      nonce_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_WORD0:  key_word0  <= cfg_data;
        CFG_KEY_WORD1:  key_word1  <= cfg_data;
        CFG_KEY_WORD2:  key_word2  <= cfg_data;
        CFG_KEY_WORD3:  key_word3  <= cfg_data;
        CFG_NONCE_LOW:  nonce_low  <= cfg_data;
        CFG_NONCE_HIGH: nonce_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word capture, count saturated at a full block
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data_low  <= in_word.data_low;
      data_high <= in_word.data_high;
      nbytes    <= (in_word.valid_bytes > FULL_BYTES) ? FULL_BYTES : in_word.valid_bytes;
      restart   <= in_word.restart;
    end
  end

  // Key schedule step: first four keys straight from the key registers
  always_comb begin
    j    = idx - RW'(4);
    zbit = (j < RW'(64)) ? SEQ_CONST[j[5:0]] : (j == RW'(65));
    unique case (idx[1:0])
      2'd0:    seed = key_word0;
      2'd1:    seed = key_word1;
      2'd2:    seed = key_word2;
      default: seed = key_word3;
    endcase
    if (idx < RW'(4)) begin
      new_key = seed;
    end else begin
      new_key = KS_CONST ^ {{(WORD_W-1){1'b0}}, zbit} ^ kw0
              ^ rotr(kw3, 3) ^ kw1 ^ rotr(kw3, 4) ^ rotr(kw1, 1);
    end
  end

  // Sliding window of the last four round keys
  always_ff @(posedge clk) begin
    if (cmd.kexp) begin
      kw0 <= kw1;
      kw1 <= kw2;
      kw2 <= kw3;
      kw3 <= new_key;
    end
  end

  // Round-key memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.kexp) begin
      mem[idx] <= new_key;
    end
    rdata <= mem[rd_addr];
  end

  // Entry valid bits; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      kvalid <= '0;
      rvalid <= 1'b0;
    end else begin
      if (cmd.kexp) begin
        kvalid[idx] <= 1'b1;
      end
      rvalid <= kvalid[rd_addr];
    end
  end

  assign rkey = rvalid ? rdata : '0;

  // Counter block
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_low  <= '0;
      ctr_high <= '0;
    end else if (cmd.load_ctr) begin
      ctr_low  <= nonce_low;
      ctr_high <= nonce_high;
    end else if (cmd.finish && nbytes == FULL_BYTES) begin
      ctr_low <= ctr_low + WORD_W'(1);
    end
  end

  // Round unit: one Feistel round a cycle
  always_ff @(posedge clk) begin
    if (cmd.load_xy) begin
      x <= ctr_high;
      y <= ctr_low;
    end else if (cmd.round) begin
      x <= y ^ round_f(x) ^ rkey;
      y <= x;
    end
  end

  // Result masking
  always_comb begin
    mask_low  = byte_mask(nbytes);
    mask_high = (nbytes > HALF_BYTES) ? byte_mask(nbytes - HALF_BYTES) : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word.out_low   <= (data_low ^ y) & mask_low;
      out_word.out_high  <= (data_high ^ x) & mask_high;
      out_word.out_bytes <= nbytes;
    end
  end

  assign status.restart  = restart;
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the Simon 128/256 counter-mode keystream core.
`timescale 1ns / 100ps

module testbench;
  import simctr_pkg::*;

  localparam int ROUND_CNT        = 72;
  localparam int FULL_BLOCK_BYTES = 16;
  localparam int HALF_BLOCK_BYTES = 8;
  localparam logic [63:0] Z_SEQ   = 64'hFDC9_4C3A_046D_678B;
  localparam logic [63:0] KS_C    = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam logic [63:0] ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
  // index with no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int RAND_PHASES      = 8;
  localparam int PHASE_WORDS      = 150;
  localparam int END_PAUSE        = 160;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;

  // model copy of registers and state
  logic [63:0] key_reg [4];
  logic [63:0] nonce_lo_reg, nonce_hi_reg;
  logic [63:0] sched [ROUND_CNT];
  logic [63:0] ctr_lo, ctr_hi;

  out_word_t   pending_blocks [$];
  int unsigned err_count    = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;

  // directed table: fixed expectation only where obvious
  typedef struct {
    bit          reconfig;  // drain, then load the extreme register set
    bit          restart;
    logic [63:0] d_lo;
    logic [63:0] d_hi;
    logic [4:0]  nbytes;
    bit          fixed;
    logic [63:0] e_lo;
    logic [63:0] e_hi;
    logic [4:0]  e_bytes;
  } dir_row_t;

  localparam int DIR_ROWS = 18;
  dir_row_t dir_tab [DIR_ROWS] = '{
    // before any restart: zero keys and counter
    '{0, 0, 64'h0, 64'h0, 5'd16, 0, 64'h0, 64'h0, 5'd0},
    '{0, 0, ALL_ONE, ALL_ONE, 5'd16, 0, 64'h0, 64'h0, 5'd0},
    '{0, 0, ALL_ONE, ALL_ONE, 5'd0, 1, 64'h0, 64'h0, 5'd0},
    '{0, 0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd31,
      0, 64'h0, 64'h0, 5'd0},
    '{0, 0, ALL_ONE, ALL_ONE, 5'd17, 0, 64'h0, 64'h0, 5'd0},
    '{0, 1, 64'h0, 64'h0, 5'd16, 0, 64'h0, 64'h0, 5'd0},
    // all-ones keys, counter two below the wrap
    '{1, 1, 64'h0, 64'h0, 5'd16, 0, 64'h0, 64'h0, 5'd0},
    '{0, 0, 64'h0, 64'h0, 5'd16, 0, 64'h0, 64'h0, 5'd0},
    '{0, 0, ALL_ONE, ALL_ONE, 5'd16, 0, 64'h0, 64'h0, 5'd0},
    '{0, 0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 5'd15,
      0, 64'h0, 64'h0, 5'd0},
    '{0, 0, ALL_ONE, ALL_ONE, 5'd9, 0, 64'h0, 64'h0, 5'd0},
    '{0, 0, ALL_ONE, ALL_ONE, 5'd8, 0, 64'h0, 64'h0, 5'd0},
    '{0, 0, ALL_ONE, ALL_ONE, 5'd7, 0, 64'h0, 64'h0, 5'd0},
    '{0, 0, ALL_ONE, ALL_ONE, 5'd1, 0, 64'h0, 64'h0, 5'd0},
    '{0, 0, ALL_ONE, ALL_ONE, 5'd0, 1, 64'h0, 64'h0, 5'd0},
    '{0, 0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 5'd16,
      0, 64'h0, 64'h0, 5'd0},
    '{0, 1, ALL_ONE, ALL_ONE, 5'd24, 0, 64'h0, 64'h0, 5'd0},
    '{0, 1, 64'h0, 64'h0, 5'd1, 0, 64'h0, 64'h0, 5'd0}
  };

  simon128_256_ctr_keystream_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // ---- keystream model ----
  function automatic logic [63:0] rol(logic [63:0] v, int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] ror(logic [63:0] v, int unsigned r);
    return (v >> r) | (v << (64 - r));
  endfunction

  function automatic logic [63:0] feistel_f(logic [63:0] v);
    return (rol(v, 1) & rol(v, 8)) ^ rol(v, 2);
  endfunction

  function automatic void expand_schedule();
    logic [63:0] a, b, z;
    for (int i = 0; i < 4; i++) sched[i] = key_reg[i];
    for (int i = 4; i < ROUND_CNT; i++) begin
      a = sched[i-1];
      b = sched[i-3];
      z = '0;
      // sequence bit: constant bits first, then one lone set bit at 65
      if (i - 4 < 64) z[0] = Z_SEQ[i-4];
      else z[0] = (i - 4 == 65);
      sched[i] = KS_C ^ z ^ sched[i-4] ^ ror(a, 3) ^ b ^ ror(a, 4) ^ ror(b, 1);
    end
  endfunction

  function automatic void encipher_ctr(output logic [63:0] xo, output logic [63:0] yo);
    logic [63:0] x, y;
    x = ctr_hi;
    y = ctr_lo;
    for (int i = 0; i + 1 < ROUND_CNT; i += 2) begin
      y ^= feistel_f(x) ^ sched[i];
      x ^= feistel_f(y) ^ sched[i+1];
    end
    xo = x;
    yo = y;
  endfunction

  function automatic logic [63:0] low_bytes(int unsigned n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) if (b < n) m[8*b +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic out_word_t predict_keystream_block(in_word_t w);
    out_word_t   r;
    int unsigned n;
    logic [63:0] x, y;
    if (w.restart) begin
      expand_schedule();
      ctr_lo = nonce_lo_reg;
      ctr_hi = nonce_hi_reg;
    end
    n = (w.valid_bytes > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : w.valid_bytes;
    encipher_ctr(x, y);
    if (n == FULL_BLOCK_BYTES) begin
      ctr_lo     = ctr_lo + 64'd1;
      r.out_low  = w.data_low ^ y;
      r.out_high = w.data_high ^ x;
    end else begin
      // partial block: counter holds, bytes past the count are zero
      r.out_low  = (w.data_low ^ y) & low_bytes(n);
      r.out_high = (n > HALF_BLOCK_BYTES) ?
                   ((w.data_high ^ x) & low_bytes(n - HALF_BLOCK_BYTES)) : '0;
    end
    r.out_bytes = BYTES_W'(n);
    return r;
  endfunction

  // ---- reporting ----
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // ---- output side: random stall and check ----
  always @(posedge clk) begin : rx_side
    out_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch("word with nothing pending", out_word.out_low, '0);
        end else begin
          want = pending_blocks.pop_front();
          if (out_word.out_low !== want.out_low)
            report_mismatch("out_low", out_word.out_low, want.out_low);
          if (out_word.out_high !== want.out_high)
            report_mismatch("out_high", out_word.out_high, want.out_high);
          if (out_word.out_bytes !== want.out_bytes)
            report_mismatch("out_bytes", 64'(out_word.out_bytes), 64'(want.out_bytes));
        end
      end
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // ---- input side ----
  function automatic int unsigned idle_gap();
    int unsigned g;
    g = 0;
    if (tx_idle_pct == 0) return 0;
    // now and then a long gap so the next word lands anywhere in a block's run
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 160);
    while (g < 64 && $urandom_range(0, 99) < tx_idle_pct) g++;
    return g;
  endfunction

  // called in the step after the previous acceptance, or with in_valid low
  task automatic send_block(input in_word_t w, input bit fixed, input out_word_t want);
    int unsigned gap;
    out_word_t   pred;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pred = predict_keystream_block(w);
    pending_blocks.push_back(fixed ? want : pred);
  endtask

  task automatic drain_pipeline();
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---- configuration ----
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_WORD0:  key_reg[0]   = val;
      CFG_KEY_WORD1:  key_reg[1]   = val;
      CFG_KEY_WORD2:  key_reg[2]   = val;
      CFG_KEY_WORD3:  key_reg[3]   = val;
      CFG_NONCE_LOW:  nonce_lo_reg = val;
      CFG_NONCE_HIGH: nonce_hi_reg = val;
      default: ;
    endcase
  endtask

  task automatic load_reg_set(input logic [63:0] k0, k1, k2, k3, nl, nh,
                              input bit spare);
    write_reg(CFG_KEY_WORD0, k0);
    write_reg(CFG_KEY_WORD1, k1);
    write_reg(CFG_KEY_WORD2, k2);
    write_reg(CFG_KEY_WORD3, k3);
    write_reg(CFG_NONCE_LOW, nl);
    write_reg(CFG_NONCE_HIGH, nh);
    if (spare) write_reg(CFG_SPARE_IDX, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ALL_ONE;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_word_t random_word(bit restart, logic [4:0] nbytes);
    in_word_t w;
    w.restart     = restart;
    w.data_low    = {$urandom, $urandom};
    w.data_high   = {$urandom, $urandom};
    w.valid_bytes = nbytes;
    // plain keystream now and then
    if ($urandom_range(0, 7) == 0) begin
      w.data_low  = '0;
      w.data_high = '0;
    end
    return w;
  endfunction

  // mostly restart + run of full words + optional partial tail, some noise
  task automatic run_random_phase(input int unsigned n_words);
    int unsigned sent, run_len;
    logic [4:0]  nb;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        send_block(random_word(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31))),
                   1'b0, '0);
        sent++;
      end else begin
        send_block(random_word(1'b1, FULL_BYTES), 1'b0, '0);
        sent++;
        run_len = $urandom_range(0, 24);
        repeat (run_len) begin
          nb = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(17, 31)) : FULL_BYTES;
          send_block(random_word(1'b0, nb), 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 1)) begin
          send_block(random_word(1'b0, 5'($urandom_range(0, 15))), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // ---- main sequence ----
  initial begin
    in_word_t    w;
    out_word_t   want;
    logic [63:0] nl;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    nonce_lo_reg = '0;
    nonce_hi_reg = '0;
    for (int i = 0; i < ROUND_CNT; i++) sched[i] = '0;
    ctr_lo = '0;
    ctr_hi = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].reconfig) begin
        in_valid <= 1'b0;
        drain_pipeline();
        load_reg_set(ALL_ONE, ALL_ONE, ALL_ONE, ALL_ONE,
                     64'hFFFF_FFFF_FFFF_FFFE, ALL_ONE, 1'b1);
      end
      w.restart       = dir_tab[i].restart;
      w.data_low      = dir_tab[i].d_lo;
      w.data_high     = dir_tab[i].d_hi;
      w.valid_bytes   = dir_tab[i].nbytes;
      want.out_low    = dir_tab[i].e_lo;
      want.out_high   = dir_tab[i].e_hi;
      want.out_bytes  = dir_tab[i].e_bytes;
      send_block(w, dir_tab[i].fixed, want);
    end

    // random phases, each with fresh registers and its own idling mix
    for (int p = 0; p < RAND_PHASES; p++) begin
      in_valid <= 1'b0;
      drain_pipeline();
      nl = pick_reg_value();
      if ($urandom_range(0, 2) == 0) nl = ALL_ONE - 64'($urandom_range(0, 20));
      load_reg_set(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                   pick_reg_value(), nl, pick_reg_value(), 1'($urandom_range(0, 1)));
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      run_random_phase(PHASE_WORDS);
    end

    in_valid <= 1'b0;
    drain_pipeline();
    repeat (END_PAUSE) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS simon128_256_ctr_keystream_core");
    end else begin
      $display("FAIL simon128_256_ctr_keystream_core");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL simon128_256_ctr_keystream_core");
    $finish;
  end

endmodule
